FILE: rtl/tcphc_pkg.sv
// ----------------------------------------------------------------------------
// tcphc_pkg
// Shared types and constants of the TCP/IPv4 header compression flow context.
// ----------------------------------------------------------------------------
package tcphc_pkg;

  // Reset value of the minimum IPv4 total length register.
  localparam logic [15:0] MIN_LEN_RESET = 16'd85;

  // Width of the reported slot number.
  localparam int SLOT_ID_W = 10;

  // The slot is src_addr modulo the table size, found by a reciprocal
  // multiplication in three pipelined steps: product, quotient, remainder.
  localparam int DIV_STEPS       = 3;
  localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

  // One flow table entry: four-tuple plus the stored seq and ack.
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] ports;
    logic [31:0] seq;
    logic [31:0] ack;
  } flow_entry_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIVIDE,
    ST_READ,
    ST_COMPARE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_write;
    logic load_in;
    logic div_step;
    logic mem_read;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic qual_in;
    logic div_last;
    logic clr_last;
  } dp_status_t;

endpackage

FILE: rtl/tcphc_if.sv
// ----------------------------------------------------------------------------
// tcphc_if
// Valid/ready channels for parsed header words and compression result words.
// ----------------------------------------------------------------------------
interface tcphc_hdr_if;
  logic        valid;
  logic        ready;
  logic        stateful_en;
  logic [15:0] total_len;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [31:0] seq_num;
  logic [31:0] ack_num;

  modport source (
    output valid, stateful_en, total_len, src_addr, dst_addr,
           src_port, dst_port, seq_num, ack_num,
    input  ready
  );
  modport sink (
    input  valid, stateful_en, total_len, src_addr, dst_addr,
           src_port, dst_port, seq_num, ack_num,
    output ready
  );
endinterface

interface tcphc_res_if;
  logic       valid;
  logic       ready;
  logic       compressed;
  logic [9:0] slot_id;
  logic       seq_change;
  logic       ack_change;
  logic [1:0] option_words;

  modport source (
    output valid, compressed, slot_id, seq_change, ack_change, option_words,
    input  ready
  );
  modport sink (
    input  valid, compressed, slot_id, seq_change, ack_change, option_words,
    output ready
  );
endinterface

FILE: rtl/tcphc_dp.sv
// ----------------------------------------------------------------------------
// tcphc_dp
// Datapath: threshold register, input capture, slot remainder unit, flow
// table memory, tuple compare and result register.
// ----------------------------------------------------------------------------
module tcphc_dp
  import tcphc_pkg::*;
#(
  parameter int TABLE_SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  input  logic        stateful_en,
  input  logic [15:0] total_len,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [15:0] src_port,
  input  logic [15:0] dst_port,
  input  logic [31:0] seq_num,
  input  logic [31:0] ack_num,
  output logic        compressed,
  output logic [9:0]  slot_id,
  output logic        seq_change,
  output logic        ack_change,
  output logic [1:0]  option_words
);

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_STEPS - 1);

  // Reciprocal of the table size: floor(2^(32+IDX_W) / TABLE_SLOTS) + 1,
  // a 33-bit constant that gives the exact quotient of any 32-bit address.
  localparam int          RECIP_SH   = 32 + IDX_W;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << RECIP_SH) / 64'(TABLE_SLOTS)) + 64'd1;
  localparam logic [31:0] RECIP_LO   = RECIP_FULL[31:0];
  localparam logic        RECIP_HI   = RECIP_FULL[32];
  localparam logic [31:0] SLOTS_W    = 32'(TABLE_SLOTS);

  logic [15:0]          min_total_len;
  logic                 qual_in;
  logic                 div_last;
  logic                 clr_last;
  logic                 qualify;
  logic [31:0]          dividend;
  logic [63:0]          prod;
  logic [64:0]          prod_sum;
  logic [31:0]          quot;
  logic [31:0]          rem_full;
  logic [IDX_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [IDX_W-1:0]     clr_cnt;
  flow_entry_t          pkt;
  flow_entry_t          rd_q;
  flow_entry_t          mem [TABLE_SLOTS];
  logic                 hit;
  logic                 hit_ok;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  flow_entry_t          mem_wdata;
  logic                 sc;
  logic                 ac;

  assign status = '{qual_in: qual_in, div_last: div_last, clr_last: clr_last};

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_total_len <= MIN_LEN_RESET;
    end else if (cfg_wr_en) begin
      min_total_len <= cfg_wr_data;
    end
  end

  // Qualification of the word on the input channel.
  assign qual_in = stateful_en && (total_len > min_total_len);

  // Capture the header word at acceptance.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      qualify   <= qual_in;
      pkt.src   <= src_addr;
      pkt.dst   <= dst_addr;
      pkt.ports <= {src_port, dst_port};
      pkt.seq   <= seq_num;
      pkt.ack   <= ack_num;
    end
  end

  // Remainder by reciprocal multiplication. Each step advances a three-stage
  // pipe over the held address: low product, quotient, remainder. After the
  // third step the remainder is valid.
  assign prod_sum = {1'b0, prod} + (RECIP_HI ? {1'b0, dividend, 32'd0} : 65'd0);
  assign rem_full = dividend - quot * SLOTS_W;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dividend <= src_addr;
      div_cnt  <= '0;
    end else if (cmd.div_step) begin
      prod     <= 64'(dividend) * 64'(RECIP_LO);
      quot     <= 32'(prod_sum >> RECIP_SH);
      rem      <= rem_full[IDX_W-1:0];
      div_cnt  <= div_cnt + 1'b1;
    end
  end

  assign div_last = (div_cnt == LAST_STEP);

  // Clearing pass address after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_write) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign clr_last = (clr_cnt == LAST_SLOT);

  // Tuple compare against the entry read from the table.
  assign hit    = (rd_q.src == pkt.src) && (rd_q.dst == pkt.dst) &&
                  (rd_q.ports == pkt.ports);
  assign hit_ok = qualify && hit;
  assign sc     = hit_ok && (rd_q.seq != pkt.seq);
  assign ac     = hit_ok && (rd_q.ack != pkt.ack);

  // Write port: zeros during the clearing pass, the new flow on a miss of a qualifying word.
  assign mem_we    = cmd.clr_write || (cmd.finish && qualify && !hit);
  assign mem_waddr = cmd.clr_write ? clr_cnt : rem;
  assign mem_wdata = cmd.clr_write ? flow_entry_t'('0) : pkt;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_read) begin
      rd_q <= mem[rem];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      compressed   <= hit_ok;
      slot_id      <= hit_ok ? SLOT_ID_W'(rem) : '0;
      seq_change   <= sc;
      ack_change   <= ac;
      option_words <= {1'b0, sc} + {1'b0, ac};
    end
  end

endmodule

FILE: rtl/tcphc_ctrl.sv
// ----------------------------------------------------------------------------
// tcphc_ctrl
// Controller: sequences the clearing pass, the remainder steps, the table
// read and the compare, and holds the result valid flag.
// ----------------------------------------------------------------------------
module tcphc_ctrl
  import tcphc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   can_finish;

  assign can_finish = !out_valid || out_ready;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = status.qual_in ? ST_DIVIDE : ST_COMPARE;
      end
      ST_DIVIDE: begin
        if (status.div_last) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_COMPARE;
      end
      ST_COMPARE: begin
        if (can_finish) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Outputs and commands.
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      ST_READ: begin
        cmd.mem_read = 1'b1;
      end
      ST_COMPARE: begin
        cmd.finish = can_finish;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // The result word stays valid until the sink takes it.
  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    if (cmd.finish) out_valid_next = 1'b1;
  end

endmodule

FILE: rtl/tcp_header_compress_context_core.sv
// ----------------------------------------------------------------------------
// tcp_header_compress_context_core
// Flow context lookup for TCP/IPv4 header compression over a direct-mapped
// table indexed by the source address modulo the table size.
//
//   Channel   Dir   Handshake     Contents
//   hdr_in    in    valid/ready   parsed IPv4/TCP header word
//   res_out   out   valid/ready   compression result word
//   cfg       in    write enable  min_total_len threshold
//
// A qualifying word passes through the product, quotient and remainder
// steps of the reciprocal-multiply remainder unit, a table read and a
// compare before its result is registered. A word that does not qualify
// goes from acceptance straight to the compare. One word is in flight at a
// time; the next one is accepted at the earliest in the cycle after the
// previous result is registered. Reset starts a clearing pass that writes
// zeros to every entry of the table memory; no word is accepted during it.
// The result register lets the compare finish while the previous result is
// taken in the same cycle; otherwise the compare waits on the sink.
// ----------------------------------------------------------------------------
module tcp_header_compress_context_core
  import tcphc_pkg::*;
#(
  parameter int TABLE_SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  tcphc_hdr_if.sink   hdr_in,
  tcphc_res_if.source res_out
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Controller.
  tcphc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hdr_in.valid),
    .in_ready  (hdr_in.ready),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath.
  tcphc_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .cmd            (cmd),
    .status         (status),
    .stateful_en    (hdr_in.stateful_en),
    .total_len      (hdr_in.total_len),
    .src_addr       (hdr_in.src_addr),
    .dst_addr       (hdr_in.dst_addr),
    .src_port       (hdr_in.src_port),
    .dst_port       (hdr_in.dst_port),
    .seq_num        (hdr_in.seq_num),
    .ack_num        (hdr_in.ack_num),
    .compressed     (res_out.compressed),
    .slot_id        (res_out.slot_id),
    .seq_change     (res_out.seq_change),
    .ack_change     (res_out.ack_change),
    .option_words   (res_out.option_words)
  );

endmodule
